@@ design/gmdc_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the grid dilation counter.
package gmdc_pkg;

  // Default largest grid side
  localparam int MaxSideDef = 128;

  // Fixed field widths
  localparam int KindW   = 2;
  localparam int CountW  = 15;
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DAYS      = 2'd1;

  // Stored cell codes. FRESH marks a cell infected during the step in progress;
  // it is never loaded from the input (input code 3 is stored as EMPTY).
  localparam logic [KindW-1:0] K_HEALTHY  = 2'd0;
  localparam logic [KindW-1:0] K_EMPTY    = 2'd1;
  localparam logic [KindW-1:0] K_INFECTED = 2'd2;
  localparam logic [KindW-1:0] K_FRESH    = 2'd3;

  // Grid memory read address select
  typedef enum logic [2:0] {
    RD_CEN,
    RD_UP,
    RD_DN,
    RD_RT,
    RD_CNT
  } gmdc_rd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;       // input request accepted
    logic     start;      // last cell accepted, arm step counter
    logic     step_init;  // rewind scan position for a spreading step
    logic     rd_en;      // grid memory read
    gmdc_rd_e rd_sel;
    logic     cap_cen;
    logic     cap_up;
    logic     cap_dn;
    logic     eval;       // update current cell and advance
    logic     cnt_init;   // rewind scan position and clear count
    logic     cnt_rd;     // counting read, advance
    logic     cnt_zero;
    logic     res_load;
  } gmdc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic days_zero;
    logic days_one;
    logic last_pos;
    logic step_more;
  } gmdc_st_t;

endpackage

@@ design/gmdc_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module gmdc_ram #(
  parameter int Width = 2,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/gmdc_dp.sv @@
// Datapath: configuration, grid memory, scan counters, neighbor evaluation and cell count.
module gmdc_dp import gmdc_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [KindW-1:0]   cell_kind_i,
  input  gmdc_cmd_t          cmd_i,
  output gmdc_st_t           st_o,
  output logic [CountW-1:0]  infected_count_o
);

  localparam int SideW  = $clog2(MAX_SIDE + 1);
  localparam int CidxW  = $clog2(MAX_SIDE);
  localparam int AddrW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int PosW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam logic [8:0] MaxSide9 = 9'(MAX_SIDE);

  // Configuration and load state
  logic [SideW-1:0] side_q;
  logic [PosW-1:0]  total_q;
  logic [CfgW-1:0]  days_q;
  logic [PosW-1:0]  load_pos_q;

  // Scan state
  logic [AddrW-1:0] pos_q;
  logic [CidxW-1:0] col_q;
  logic [CidxW-1:0] row_q;
  logic [CfgW-1:0]  steps_q;
  logic             any_q;
  logic             cnt_vld_q;

  // Cell window and results
  logic [KindW-1:0]  cen_q, up_q, dn_q, left_q;
  logic [CountW-1:0] cnt_q, res_q;

  // Clamp of a new side and its square
  logic [8:0]         side_cl;
  logic [SideW-1:0]   side_new;
  logic [2*SideW-1:0] side_sq;

  always_comb begin
    if (cfg_data_i == '0) begin
      side_cl = 9'd1;
    end else if ({1'b0, cfg_data_i} > MaxSide9) begin
      side_cl = MaxSide9;
    end else begin
      side_cl = {1'b0, cfg_data_i};
    end
    side_new = side_cl[SideW-1:0];
    side_sq  = side_new * side_new;
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SideW'(1);
      total_q <= PosW'(1);
      days_q  <= CfgW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_SIZE: begin
          side_q  <= side_new;
          total_q <= side_sq[PosW-1:0];
        end
        CFG_DAYS: begin
          days_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Scan geometry
  logic [SideW-1:0] side_m1;
  logic [PosW-1:0]  total_m1;
  logic             col_last, row_last;

  assign side_m1  = side_q - SideW'(1);
  assign total_m1 = total_q - PosW'(1);
  assign col_last = SideW'(col_q) == side_m1;
  assign row_last = SideW'(row_q) == side_m1;

  // Load path: input code 3 is stored as empty
  logic             load_wr;
  logic [KindW-1:0] load_code;

  assign load_wr   = cmd_i.load && (load_pos_q < total_q);
  assign load_code = (cell_kind_i == K_FRESH) ? K_EMPTY : cell_kind_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
    end else if (cmd_i.start) begin
      load_pos_q <= '0;
    end else if (load_wr) begin
      load_pos_q <= load_pos_q + PosW'(1);
    end
  end

  // Grid memory
  logic [AddrW-1:0] rd_addr;
  logic [KindW-1:0] rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [KindW-1:0] wr_data;
  logic [KindW-1:0] new_code;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_UP:   rd_addr = pos_q - AddrW'(side_q);
      RD_DN:   rd_addr = pos_q + AddrW'(side_q);
      RD_RT:   rd_addr = pos_q + AddrW'(1);
      default: rd_addr = pos_q;
    endcase
  end

  assign wr_en   = load_wr || cmd_i.eval;
  assign wr_addr = load_wr ? load_pos_q[AddrW-1:0] : pos_q;
  assign wr_data = load_wr ? load_code : new_code;

  gmdc_ram #(
    .Width (KindW),
    .Depth (MAX_SIDE * MAX_SIDE)
  ) u_grid (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Neighbor test. Up and left are already updated in this step, so FRESH
  // there means healthy at step start; down and right are not yet visited.
  logic up_inf, lf_inf, dn_inf, rt_inf, chg;

  always_comb begin
    up_inf = (row_q != '0) && (up_q == K_INFECTED);
    lf_inf = (col_q != '0) && (left_q == K_INFECTED);
    dn_inf = !row_last && ((dn_q == K_INFECTED) || (dn_q == K_FRESH));
    rt_inf = !col_last && ((rd_data == K_INFECTED) || (rd_data == K_FRESH));
    chg    = (cen_q == K_HEALTHY) && (up_inf || lf_inf || dn_inf || rt_inf);
    if (chg) begin
      new_code = K_FRESH;
    end else if (cen_q == K_FRESH) begin
      new_code = K_INFECTED;
    end else begin
      new_code = cen_q;
    end
  end

  // Scan counters and step bookkeeping; a rewind wins over an advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      steps_q   <= '0;
      any_q     <= 1'b0;
      cnt_vld_q <= 1'b0;
    end else begin
      cnt_vld_q <= cmd_i.cnt_rd;
      if (cmd_i.start) begin
        steps_q <= days_q - CfgW'(1);
      end else if (cmd_i.eval && st_o.last_pos) begin
        steps_q <= steps_q - CfgW'(1);
      end
      if (cmd_i.step_init || cmd_i.cnt_init) begin
        pos_q <= '0;
        col_q <= '0;
        row_q <= '0;
        any_q <= 1'b0;
      end else if (cmd_i.eval) begin
        pos_q <= pos_q + AddrW'(1);
        any_q <= any_q || chg;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + CidxW'(1);
        end else begin
          col_q <= col_q + CidxW'(1);
        end
      end else if (cmd_i.cnt_rd) begin
        pos_q <= pos_q + AddrW'(1);
      end
    end
  end

  // Cell window
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cen) begin
      cen_q <= rd_data;
    end
    if (cmd_i.cap_up) begin
      up_q <= rd_data;
    end
    if (cmd_i.cap_dn) begin
      dn_q <= rd_data;
    end
    if (cmd_i.eval) begin
      left_q <= new_code;
      cen_q  <= rd_data;
    end
  end

  // Infected count, saturating
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_init || cmd_i.cnt_zero) begin
      cnt_q <= '0;
    end else if (cnt_vld_q && ((rd_data == K_INFECTED) || (rd_data == K_FRESH))
                 && (cnt_q != '1)) begin
      cnt_q <= cnt_q + CountW'(1);
    end
    if (cmd_i.res_load) begin
      res_q <= cnt_q;
    end
  end

  assign infected_count_o = res_q;

  // Status
  assign st_o.days_zero = (days_q == '0);
  assign st_o.days_one  = (days_q == CfgW'(1));
  assign st_o.last_pos  = (pos_q == total_m1[AddrW-1:0]);
  assign st_o.step_more = (steps_q != CfgW'(1)) && (any_q || chg);

endmodule

@@ design/gmdc_ctrl.sv @@
// Controller: sequences loading, spreading steps, the counting sweep and the result request.
module gmdc_ctrl import gmdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_cell_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gmdc_st_t  st_i,
  output gmdc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ST0  = 4'd1;
  localparam logic [3:0] S_ST1  = 4'd2;
  localparam logic [3:0] S_UP   = 4'd3;
  localparam logic [3:0] S_DN   = 4'd4;
  localparam logic [3:0] S_RT   = 4'd5;
  localparam logic [3:0] S_EV   = 4'd6;
  localparam logic [3:0] S_CNT  = 4'd7;
  localparam logic [3:0] S_CNTT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_CEN;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_acc;
        if (in_acc && last_cell_i) begin
          cmd_o.start = 1'b1;
          if (st_i.days_zero) begin
            cmd_o.cnt_zero = 1'b1;
            state_d = S_DONE;
          end else if (st_i.days_one) begin
            cmd_o.cnt_init = 1'b1;
            state_d = S_CNT;
          end else begin
            cmd_o.step_init = 1'b1;
            state_d = S_ST0;
          end
        end
      end
      S_ST0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CEN;
        state_d = S_ST1;
      end
      S_ST1: begin
        cmd_o.cap_cen = 1'b1;
        state_d = S_UP;
      end
      S_UP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_UP;
        state_d = S_DN;
      end
      S_DN: begin
        cmd_o.cap_up = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_DN;
        state_d = S_RT;
      end
      S_RT: begin
        cmd_o.cap_dn = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RT;
        state_d = S_EV;
      end
      S_EV: begin
        cmd_o.eval = 1'b1;
        if (!st_i.last_pos) begin
          state_d = S_UP;
        end else if (st_i.step_more) begin
          cmd_o.step_init = 1'b1;
          state_d = S_ST0;
        end else begin
          cmd_o.cnt_init = 1'b1;
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CNT;
        cmd_o.cnt_rd = 1'b1;
        if (st_i.last_pos) begin
          state_d = S_CNTT;
        end
      end
      S_CNTT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output request valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/grid_masked_dilation_count.sv @@
// Loading takes one cell per cycle. After the last cell, each spreading step makes three grid memory
// reads and one write per cell, then a count sweep reads every cell, and the result request is
// offered once the output is free; steps stop early once a step changes no cell. The grid memory
// has one read port, so the reads of each cell are made one after another.
// Reset sets grid_size to 1, days to 1 and the load position to 0; the grid is not cleared.
module grid_masked_dilation_count import gmdc_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   cell_kind_i,
  input  logic               last_cell_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CountW-1:0]  infected_count_o
);

  gmdc_cmd_t cmd;
  gmdc_st_t  st;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  gmdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_cell_i (last_cell_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  gmdc_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cell_kind_i      (cell_kind_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .infected_count_o (infected_count_o)
  );

endmodule

@@ test/grid_masked_dilation_count_tb.sv @@
// Self-checking testbench for the grid dilation counter: random grids checked against a predictor.
`timescale 1ns / 1ps

// Predicts the infected count of each grid and holds the counts still owed by the block
class dilation_scoreboard;
  localparam int MaxSide  = gmdc_pkg::MaxSideDef;
  localparam int MaxCells = MaxSide * MaxSide;
  localparam int CountMax = (1 << gmdc_pkg::CountW) - 1;

  logic [gmdc_pkg::KindW-1:0]  cells [MaxCells];
  bit                          caught [MaxCells];
  int unsigned                 load_pos;
  int unsigned                 filled_upto;  // cells [0, filled_upto) were written at least once
  logic [gmdc_pkg::CfgW-1:0]   side_reg;
  logic [gmdc_pkg::CfgW-1:0]   days_reg;
  logic [gmdc_pkg::CountW-1:0] expected_counts [$];
  int unsigned                 mismatches;

  function new();
    load_pos    = 0;
    filled_upto = 0;
    side_reg    = 8'd1;
    days_reg    = 8'd1;
    mismatches  = 0;
    foreach (cells[p]) cells[p] = gmdc_pkg::K_HEALTHY;
  endfunction

  function void write_reg(logic [gmdc_pkg::CfgIdxW-1:0] idx, logic [gmdc_pkg::CfgW-1:0] val);
    case (idx)
      gmdc_pkg::CFG_GRID_SIZE: side_reg = val;
      gmdc_pkg::CFG_DAYS:      days_reg = val;
      default: ;
    endcase
  endfunction

  // Side in use: zero acts as one, oversize clamps to the largest side
  function int unsigned side();
    int unsigned n;
    n = side_reg;
    if (n < 1) n = 1;
    if (n > MaxSide) n = MaxSide;
    return n;
  endfunction

  // One spreading step, all cells at once; returns whether anything changed
  function bit spread_once(int unsigned n);
    int unsigned total;
    int unsigned r;
    int unsigned c;
    bit          hit;
    bit          any;
    total = n * n;
    any = 1'b0;
    for (int unsigned p = 0; p < total; p++) begin
      caught[p] = 1'b0;
      if (cells[p] != gmdc_pkg::K_HEALTHY) continue;
      r = p / n;
      c = p % n;
      hit = 1'b0;
      if (r > 0 && cells[p - n] == gmdc_pkg::K_INFECTED) hit = 1'b1;
      if (r + 1 < n && cells[p + n] == gmdc_pkg::K_INFECTED) hit = 1'b1;
      if (c > 0 && cells[p - 1] == gmdc_pkg::K_INFECTED) hit = 1'b1;
      if (c + 1 < n && cells[p + 1] == gmdc_pkg::K_INFECTED) hit = 1'b1;
      if (hit) begin
        caught[p] = 1'b1;
        any = 1'b1;
      end
    end
    for (int unsigned p = 0; p < total; p++)
      if (caught[p]) cells[p] = gmdc_pkg::K_INFECTED;
    return any;
  endfunction

  // Accepted cell request: store it, and on the last cell work out the count
  function void note_cell(logic [gmdc_pkg::KindW-1:0] kind, logic last);
    int unsigned n;
    int unsigned total;
    int unsigned count;
    n = side();
    total = n * n;
    if (load_pos < total) begin
      // the spare kind code behaves as an empty cell
      cells[load_pos] = (kind == gmdc_pkg::K_FRESH) ? gmdc_pkg::K_EMPTY : kind;
      load_pos++;
      if (load_pos > filled_upto) filled_upto = load_pos;
    end
    if (!last) return;
    count = 0;
    if (days_reg != 0) begin
      for (int unsigned d = 1; d < days_reg; d++)
        if (!spread_once(n)) break;
      for (int unsigned p = 0; p < total; p++)
        if (cells[p] == gmdc_pkg::K_INFECTED) count++;
    end
    if (count > CountMax) count = CountMax;
    expected_counts.push_back(count[gmdc_pkg::CountW-1:0]);
    load_pos = 0;
  endfunction

  function void check_count(logic [gmdc_pkg::CountW-1:0] got);
    logic [gmdc_pkg::CountW-1:0] want;
    if (expected_counts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected infected_count %0d, no count pending", got);
      return;
    end
    want = expected_counts.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("infected_count mismatch: expected %0d, actual %0d", want, got);
    end
  endfunction

  function int unsigned failures();
    return mismatches + expected_counts.size();
  endfunction
endclass

module grid_masked_dilation_count_tb import gmdc_pkg::*; ;

  localparam int MaxSide = MaxSideDef;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;
  localparam int SettleCycles = 6;
  localparam int LongHoldCycles = 400;
  localparam int RandomCells = 640;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KindW-1:0]   cell_kind_i;
  logic               last_cell_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CountW-1:0]  infected_count_o;

  dilation_scoreboard sb;
  bit tx_burst;
  int hold_cycles;

  grid_masked_dilation_count #(.MAX_SIDE(MaxSide)) DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit, well above the slowest correct run
  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Random kind: mostly healthy, some empty, a few spare codes, infected at the given rate
  function automatic logic [KindW-1:0] draw_kind(int unsigned infect_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < infect_pct) return K_INFECTED;
    if (r < infect_pct + 20) return K_EMPTY;
    if (r < infect_pct + 23) return K_FRESH;
    return K_HEALTHY;
  endfunction

  // Cell request; valid stays up from one request to the next when no gap is drawn
  task automatic send_cell(input logic [KindW-1:0] kind, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_kind_i <= kind;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_cell(kind, last);
  endtask

  task automatic send_frame(input int unsigned cells, input int unsigned infect_pct);
    for (int unsigned i = 0; i < cells; i++)
      send_cell(draw_kind(infect_pct), i == cells - 1);
  endtask

  // Stop offering and wait until every count has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_counts.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stalls, burst stretches, and a long hold-off on request
  initial begin
    int  gap;
    bit  rx_burst;
    out_ready_i = 1'b0;
    rx_burst = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_count(infected_count_o);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [KindW-1:0] plus_shape [9];
    logic [KindW-1:0] overfill [6];
    int unsigned n;
    int unsigned total;
    int unsigned cells;
    int unsigned r;
    int unsigned random_cells;

    sb = new();
    hold_cycles = 0;
    tx_burst = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cell_kind_i = K_HEALTHY;
    last_cell_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_SIZE;
    cfg_data_i = '0;
    random_cells = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: one cell, day one
    send_cell(K_INFECTED, 1'b1);

    // Writes to unused indexes change nothing
    settle();
    write_reg(CFG_SPARE_2, 8'hFF);
    write_reg(CFG_SPARE_3, 8'h00);
    send_cell(K_HEALTHY, 1'b1);

    // 3x3 with one infected center, an empty cell and a spare code, one step
    plus_shape[0] = K_HEALTHY;  plus_shape[1] = K_HEALTHY;  plus_shape[2] = K_EMPTY;
    plus_shape[3] = K_HEALTHY;  plus_shape[4] = K_INFECTED; plus_shape[5] = K_HEALTHY;
    plus_shape[6] = K_HEALTHY;  plus_shape[7] = K_HEALTHY;  plus_shape[8] = K_FRESH;
    settle();
    write_reg(CFG_GRID_SIZE, 8'd3);
    write_reg(CFG_DAYS, 8'd2);
    foreach (plus_shape[i]) send_cell(plus_shape[i], i == 8);

    // Day zero, then the longest day count, both with one-cell frames on the 3x3 grid reusing stored cells
    settle();
    write_reg(CFG_DAYS, 8'd0);
    send_cell(K_INFECTED, 1'b1);
    settle();
    write_reg(CFG_DAYS, 8'd255);
    send_cell(K_HEALTHY, 1'b1);

    // Cells past the end of a 2x2 grid are dropped
    overfill[0] = K_INFECTED; overfill[1] = K_FRESH;    overfill[2] = K_HEALTHY;
    overfill[3] = K_EMPTY;    overfill[4] = K_INFECTED; overfill[5] = K_HEALTHY;
    settle();
    write_reg(CFG_GRID_SIZE, 8'd2);
    write_reg(CFG_DAYS, 8'd1);
    foreach (overfill[i]) send_cell(overfill[i], i == 5);

    // Side zero acts as one
    settle();
    write_reg(CFG_GRID_SIZE, 8'd0);
    send_cell(K_FRESH, 1'b1);

    // Long result hold-off while single-cell grids keep coming
    settle();
    write_reg(CFG_GRID_SIZE, 8'd1);
    hold_cycles = LongHoldCycles;
    tx_burst = 1'b1;
    repeat (24) send_frame(1, 50);
    tx_burst = 1'b0;

    // Random grids, small sides, mostly well-formed frames
    while (random_cells < RandomCells) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        if (r == 0) write_reg(CFG_GRID_SIZE, 8'd0);
        else if (r < 3) write_reg(CFG_GRID_SIZE, 8'($urandom_range(7, 10)));
        else write_reg(CFG_GRID_SIZE, 8'($urandom_range(1, 6)));
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        if (r < 3) write_reg(CFG_DAYS, 8'd0);
        else if (r < 5) write_reg(CFG_DAYS, 8'd255);
        else if (r < 8) write_reg(CFG_DAYS, 8'($urandom_range(7, 40)));
        else write_reg(CFG_DAYS, 8'($urandom_range(1, 6)));
      end
      repeat ($urandom_range(1, 4)) begin
        n = sb.side();
        total = n * n;
        tx_burst = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 9);
        // short frames only where every cell in the grid has been written before
        if (r == 0) cells = total + $urandom_range(1, 3);
        else if (r == 1 && total > 1 && sb.filled_upto >= total)
          cells = $urandom_range(1, total - 1);
        else cells = total;
        send_frame(cells, $urandom_range(0, 30));
        random_cells += (cells < total) ? cells : total;
      end
    end
    tx_burst = 1'b0;

    // Oversize side acts as the largest side; day zero reads no stored cell
    settle();
    write_reg(CFG_GRID_SIZE, 8'd255);
    write_reg(CFG_DAYS, 8'd0);
    send_frame(5, 10);

    settle();
    repeat (20) @(negedge clk_i);
    if (sb.failures() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
